FILE: rtl/joystick_to_drive_command_core_defines.svh
// Assertion helpers used by the RTL (jdc_back).
`ifndef JOYSTICK_TO_DRIVE_COMMAND_CORE_DEFINES_SVH
`define JOYSTICK_TO_DRIVE_COMMAND_CORE_DEFINES_SVH

`define JDC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define JDC_ASSERT(label, prop, msg) `JDC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/jdc_pkg.sv
package jdc_pkg;

  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned ZONE_W     = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned SPAN_W     = 16;
  localparam int unsigned NUM_W      = 10;
  localparam int unsigned PROD_W     = 18;
  localparam int unsigned QUO_W      = 8;
  localparam int unsigned SPEED_W    = 8;

  localparam logic [SPEED_W-1:0]  SPEED_MAX      = 8'd220;
  localparam logic [SPEED_W-1:0]  STOP_THRESHOLD = 8'd40;
  localparam logic [SAMPLE_W-1:0] CENTRE_RESET   = 10'd512;
  localparam logic [ZONE_W-1:0]   ZONE_RESET     = 9'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTRE_X  = 2'd0,
    CFG_CENTRE_Y  = 2'd1,
    CFG_DEAD_ZONE = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CMD_STOP     = 3'd0,
    CMD_FORWARD  = 3'd1,
    CMD_BACKWARD = 3'd2,
    CMD_RIGHT    = 3'd3,
    CMD_LEFT     = 3'd4
  } cmd_e;

  typedef struct packed {
    logic              active;
    logic              neg;
    logic              sat;
    logic [NUM_W-1:0]  num;
    logic [SPAN_W-1:0] span;
  } axis_cls_t;

  typedef struct packed {
    axis_cls_t x;
    axis_cls_t y;
  } pair_t;

  typedef struct packed {
    logic              active;
    logic              neg;
    logic              sat;
    logic [SPAN_W-1:0] span;
    logic [PROD_W-1:0] rem;
    logic [QUO_W-1:0]  quo;
  } axis_div_t;

  typedef struct packed {
    axis_div_t x;
    axis_div_t y;
  } div_pair_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [SPEED_W-1:0] speed;
  } res_t;

endpackage

FILE: rtl/joystick_to_drive_command_core.sv
// A pair is classified, held in the mid queue, divided in the pipeline, then queued for output.
// Throughput: one pair per cycle when not stalled; a load stage feeds eight divide-step stages.
// The pipeline stalls as a whole only while the output queue is full.
// Reset (rst_ni low, asynchronous): queues and pipeline emptied, centres 512, dead zone 0.
module joystick_to_drive_command_core #(
  parameter int unsigned SAMPLE_FULL_SCALE = 1023,
  parameter int unsigned QUEUE_DEPTH       = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [jdc_pkg::SAMPLE_W-1:0]   x_sample_i,
  input  logic [jdc_pkg::SAMPLE_W-1:0]   y_sample_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [2:0]                     drive_command_o,
  output logic [jdc_pkg::SPEED_W-1:0]    drive_speed_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [jdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jdc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import jdc_pkg::*;

  pair_t front_item, mid_item;
  logic  front_push, mid_full, mid_empty, mid_pop;
  res_t  back_res, out_res;
  logic  back_push, out_full;

  jdc_front #(
    .SAMPLE_FULL_SCALE(SAMPLE_FULL_SCALE)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .x_sample_i  (x_sample_i),
    .y_sample_i  (y_sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (mid_full),
    .item_o      (front_item),
    .item_push_o (front_push)
  );

  jdc_queue #(
    .T    (pair_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .data_i (front_item),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .empty_o(mid_empty),
    .data_o (mid_item)
  );

  jdc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_empty_i(mid_empty),
    .mid_item_i (mid_item),
    .mid_pop_o  (mid_pop),
    .out_full_i (out_full),
    .res_o      (back_res),
    .res_push_o (back_push)
  );

  jdc_queue #(
    .T    (res_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_push),
    .data_i (back_res),
    .full_o (out_full),
    .pop_i  (pop),
    .empty_o(empty),
    .data_o (out_res)
  );

  assign drive_command_o = out_res.cmd;
  assign drive_speed_o   = out_res.speed;

endmodule

FILE: rtl/jdc_queue.sv
module jdc_queue #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output T     data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/jdc_front.sv
module jdc_front #(
  parameter int unsigned SAMPLE_FULL_SCALE = 1023
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [jdc_pkg::SAMPLE_W-1:0]     x_sample_i,
  input  logic [jdc_pkg::SAMPLE_W-1:0]     y_sample_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [jdc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [jdc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             q_full_i,
  output jdc_pkg::pair_t                   item_o,
  output logic                             item_push_o
);

  import jdc_pkg::*;

  localparam int unsigned SpanSW = SPAN_W + 2;
  localparam logic signed [SpanSW-1:0] FullScale = SpanSW'(SAMPLE_FULL_SCALE);

  logic [SAMPLE_W-1:0] centre_x_q, centre_x_d;
  logic [SAMPLE_W-1:0] centre_y_q, centre_y_d;
  logic [ZONE_W-1:0]   zone_q, zone_d;
  logic                cfg_we;

  function automatic axis_cls_t classify(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] c,
                                         logic [ZONE_W-1:0] z);
    axis_cls_t                r;
    logic signed [11:0]       d;
    logic signed [11:0]       zs;
    logic signed [SpanSW-1:0] up_span;
    logic                     upper;
    logic                     lower;
    d       = $signed({2'b00, s}) - $signed({2'b00, c});
    zs      = $signed({3'b000, z});
    up_span = FullScale - $signed(SpanSW'(c)) - $signed(SpanSW'(z));
    upper   = (d > zs);
    lower   = (d < -zs);
    r.active = upper || lower;
    r.neg    = lower;
    r.sat    = 1'b0;
    r.num    = '0;
    r.span   = '0;
    if (upper) begin
      r.num = NUM_W'(d - zs);
      if (up_span <= 0) begin
        r.sat = 1'b1;
      end else begin
        r.span = SPAN_W'(up_span);
      end
    end else if (lower) begin
      r.num  = NUM_W'(-d - zs);
      r.span = SPAN_W'(c - SAMPLE_W'(z));
    end
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    centre_x_d = centre_x_q;
    centre_y_d = centre_y_q;
    zone_d     = zone_q;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_CENTRE_X:  centre_x_d = cfg_data_i;
        CFG_CENTRE_Y:  centre_y_d = cfg_data_i;
        CFG_DEAD_ZONE: zone_d     = cfg_data_i[ZONE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      centre_x_q <= CENTRE_RESET;
      centre_y_q <= CENTRE_RESET;
      zone_q     <= ZONE_RESET;
    end else begin
      centre_x_q <= centre_x_d;
      centre_y_q <= centre_y_d;
      zone_q     <= zone_d;
    end
  end

  assign full_o      = q_full_i;
  assign item_push_o = push_i && !q_full_i;
  assign item_o.x    = classify(x_sample_i, centre_x_q, zone_q);
  assign item_o.y    = classify(y_sample_i, centre_y_q, zone_q);

endmodule

FILE: rtl/jdc_back.sv
`include "joystick_to_drive_command_core_defines.svh"

module jdc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           mid_empty_i,
  input  jdc_pkg::pair_t mid_item_i,
  output logic           mid_pop_o,
  input  logic           out_full_i,
  output jdc_pkg::res_t  res_o,
  output logic           res_push_o
);

  import jdc_pkg::*;

  localparam int unsigned NumStages = QUO_W + 1;
  localparam int unsigned Last      = NumStages - 1;
  localparam int unsigned DivW      = SPAN_W + QUO_W;

  div_pair_t          stg_q [NumStages];
  logic [Last:0]      vld_q;
  logic               advance;
  logic [SPEED_W-1:0] mag_x, mag_y;

  function automatic axis_div_t load(axis_cls_t a);
    axis_div_t         r;
    logic [PROD_W-1:0] prod;
    prod     = PROD_W'(a.num) * PROD_W'(SPEED_MAX);
    r.active = a.active;
    r.neg    = a.neg;
    r.span   = a.span;
    r.rem    = prod;
    r.quo    = '0;
    r.sat    = a.sat || (SPAN_W'(prod[PROD_W-1:QUO_W]) >= a.span);
    return r;
  endfunction

  function automatic axis_div_t div_step(axis_div_t a, logic [2:0] k);
    axis_div_t       r;
    logic [DivW-1:0] cmp;
    logic [DivW-1:0] rem_ext;
    r       = a;
    cmp     = DivW'(a.span) << k;
    rem_ext = DivW'(a.rem);
    if (rem_ext >= cmp) begin
      r.rem    = PROD_W'(rem_ext - cmp);
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [SPEED_W-1:0] axis_mag(axis_div_t a);
    logic [SPEED_W-1:0] m;
    if (!a.active) begin
      m = '0;
    end else if (a.sat || (a.quo > SPEED_MAX)) begin
      m = SPEED_MAX;
    end else begin
      m = a.quo;
    end
    return m;
  endfunction

  assign advance    = !(vld_q[Last] && out_full_i);
  assign mid_pop_o  = advance && !mid_empty_i;
  assign res_push_o = vld_q[Last] && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[Last-1:0], mid_pop_o};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stg_q[0].x <= load(mid_item_i.x);
      stg_q[0].y <= load(mid_item_i.y);
    end
  end

  for (genvar i = 1; i < NumStages; i++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (advance) begin
        stg_q[i].x <= div_step(stg_q[i-1].x, 3'(NumStages - 1 - i));
        stg_q[i].y <= div_step(stg_q[i-1].y, 3'(NumStages - 1 - i));
      end
    end
  end

  assign mag_x = axis_mag(stg_q[Last].x);
  assign mag_y = axis_mag(stg_q[Last].y);

  always_comb begin
    if ((mag_x < STOP_THRESHOLD) && (mag_y < STOP_THRESHOLD)) begin
      res_o.cmd   = CMD_STOP;
      res_o.speed = '0;
    end else if (mag_y > mag_x) begin
      res_o.cmd   = stg_q[Last].y.neg ? CMD_FORWARD : CMD_BACKWARD;
      res_o.speed = mag_y;
    end else begin
      res_o.cmd   = stg_q[Last].x.neg ? CMD_LEFT : CMD_RIGHT;
      res_o.speed = mag_x;
    end
  end

  `JDC_ASSERT(a_stall_hold, (vld_q[Last] && out_full_i) |=> (vld_q[Last] && $stable(stg_q[Last])), "stalled result changed")
  `JDC_ASSERT(a_speed_max, res_push_o |-> (res_o.speed <= SPEED_MAX), "speed above limit")
  `JDC_ASSERT(a_stop_zero, (res_push_o && (res_o.cmd == CMD_STOP)) |-> (res_o.speed == '0), "stop with nonzero speed")
  `JDC_ASSERT(a_move_min, (res_push_o && (res_o.cmd != CMD_STOP)) |-> (res_o.speed >= STOP_THRESHOLD), "move below threshold")

endmodule
